FILE: rtl/core/pcde_pkg.sv
// Shared types and constants for the prefix category difference encoder.
package pcde_pkg;

  localparam int unsigned NumLevels = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LEN0  = 3'd0;
  localparam logic [2:0] REG_LEN1  = 3'd1;
  localparam logic [2:0] REG_LEN2  = 3'd2;
  localparam logic [2:0] REG_LEN3  = 3'd3;
  localparam logic [2:0] REG_BASE0 = 3'd4;
  localparam logic [2:0] REG_BASE1 = 3'd5;
  localparam logic [2:0] REG_BASE2 = 3'd6;
  localparam logic [2:0] REG_BASE3 = 3'd7;

  // register reset values
  localparam logic [3:0] LEN0_RESET  = 4'd1;
  localparam logic [3:0] LEN1_RESET  = 4'd2;
  localparam logic [3:0] LEN2_RESET  = 4'd4;
  localparam logic [3:0] LEN3_RESET  = 4'd8;
  localparam logic [7:0] BASE0_RESET = 8'd0;
  localparam logic [7:0] BASE1_RESET = 8'd2;
  localparam logic [7:0] BASE2_RESET = 8'd6;
  localparam logic [7:0] BASE3_RESET = 8'd22;

  // longest value field; larger length settings saturate here
  localparam logic [3:0] MAX_LEN = 4'd8;

  typedef logic [2:0] pfx_code_t;
  typedef logic [1:0] pfx_size_t;

  localparam pfx_code_t PFX_CODE [NumLevels] = '{3'b000, 3'b010, 3'b110, 3'b111};
  localparam pfx_size_t PFX_SIZE [NumLevels] = '{2'd1, 2'd2, 2'd3, 2'd3};

  // one result waiting on the output side
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
    logic       no_category;
  } res_t;

endpackage

FILE: rtl/core/prefix_category_diff_encoder_unit.sv
// Top level of the prefix category difference encoder with its output queue.
//
//  channel  | direction | transfer contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata = diff[7:0], tlast = end_of_block
//  m_axis   | out       | tdata = packed_byte, tlast = final_byte,
//           |           | tuser = no_category
//  cfg      | in        | cfg_we / cfg_addr / cfg_data, one register a cycle
//
// An item is encoded in the cycle it is taken and its results (zero to three)
// land in a three-entry result queue; the queue drains one result a cycle
// unless the output stalls. A new item is taken whenever the queue will be
// empty at the clock edge, so items producing at most one result flow at one
// per cycle likewise; otherwise the next item waits until one result is left.
// rst clears the bit accumulator and queue and resets the category registers.
// An output stall holds the queue head; input waits until the queue drains.
module prefix_category_diff_encoder_unit
  import pcde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] diff
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] packed_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] no_category
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_data
);

  logic [3:0] len_level  [NumLevels];
  logic [7:0] base_level [NumLevels];

  logic [6:0] pending_bits;
  logic [2:0] pending_count;
  logic [6:0] pending_bits_next;
  logic [2:0] pending_count_next;

  res_t       res_q [3];
  logic [1:0] res_cnt;

  logic       in_xfer;
  logic       out_xfer;

  // encode
  logic                 neg;
  logic [8:0]           mag;
  logic [8:0]           rel   [NumLevels];
  logic [3:0]           eff_len [NumLevels];
  logic [NumLevels-1:0] fit;
  logic                 dropped;
  logic [1:0]           sel;
  logic [3:0]           vlen;
  logic [7:0]           val;
  logic [10:0]          body;
  logic [11:0]          code;
  logic [3:0]           nl;
  logic [18:0]          acc;
  logic [4:0]           total;
  logic [23:0]          aligned;
  logic [1:0]           nbytes;
  logic [2:0]           rem;
  logic [7:0]           rem_mask;
  logic [7:0]           flush_byte;
  res_t                 res_new [3];
  logic [1:0]           k;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && m_axis_tready);

  assign neg = s_axis_tdata[7];
  assign mag = neg ? (9'd256 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};

  always_comb begin
    for (int i = 0; i < NumLevels; i++) begin
      eff_len[i] = (len_level[i] > MAX_LEN) ? MAX_LEN : len_level[i];
      rel[i]     = mag - {1'b0, base_level[i]};
      fit[i]     = (mag >= {1'b0, base_level[i]}) && ((rel[i] >> eff_len[i]) == 9'd0);
    end
  end

  // first matching category wins
  always_comb begin
    dropped = 1'b0;
    sel     = 2'd3;
    if (fit[0]) begin
      sel = 2'd0;
    end else if (fit[1]) begin
      sel = 2'd1;
    end else if (fit[2]) begin
      sel = 2'd2;
    end else if (!fit[3]) begin
      dropped = 1'b1;
    end
  end

  always_comb begin
    vlen = eff_len[sel];
    val  = rel[sel][7:0];
    body = (11'(PFX_CODE[sel]) << vlen) | {3'b000, val};
    code = {body, neg};
    nl   = dropped ? 4'd0 : (4'(PFX_SIZE[sel]) + vlen + 4'd1);
    acc  = (19'(pending_bits) << nl) | (dropped ? 19'd0 : {7'd0, code});
    total   = {2'b00, pending_count} + {1'b0, nl};
    aligned = {5'd0, acc} << (5'd24 - total);
    nbytes  = total[4:3];
    rem     = total[2:0];
    rem_mask = (8'd1 << rem) - 8'd1;
    case (nbytes)
      2'd0:    flush_byte = aligned[23:16];
      2'd1:    flush_byte = aligned[15:8];
      2'd2:    flush_byte = aligned[7:0];
      default: flush_byte = 8'd0;
    endcase
  end

  // list the item's results in order
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      res_new[j] = '0;
    end
    k = 2'd0;
    if (dropped) begin
      res_new[k].no_category = 1'b1;
      k = k + 2'd1;
    end
    if (nbytes >= 2'd1) begin
      res_new[k].packed_byte = aligned[23:16];
      k = k + 2'd1;
    end
    if (nbytes >= 2'd2) begin
      res_new[k].packed_byte = aligned[15:8];
      k = k + 2'd1;
    end
    if (s_axis_tlast) begin
      if (rem != 3'd0) begin
        res_new[k].packed_byte = flush_byte;
        res_new[k].final_byte  = 1'b1;
        k = k + 2'd1;
      end else if (nbytes != 2'd0 && !dropped) begin
        res_new[k - 2'd1].final_byte = 1'b1;
      end
    end
  end

  always_comb begin
    if (s_axis_tlast) begin
      pending_bits_next  = 7'd0;
      pending_count_next = 3'd0;
    end else begin
      pending_bits_next  = acc[6:0] & rem_mask[6:0];
      pending_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
    end else if (in_xfer) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  // result queue; head in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (in_xfer) begin
      res_cnt <= k;
    end else if (out_xfer) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_q <= res_new;
    end else if (out_xfer) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tvalid = (res_cnt != 2'd0);
  assign m_axis_tdata  = res_q[0].packed_byte;
  assign m_axis_tlast  = res_q[0].final_byte;
  assign m_axis_tuser  = res_q[0].no_category;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_level[0]  <= LEN0_RESET;
      len_level[1]  <= LEN1_RESET;
      len_level[2]  <= LEN2_RESET;
      len_level[3]  <= LEN3_RESET;
      base_level[0] <= BASE0_RESET;
      base_level[1] <= BASE1_RESET;
      base_level[2] <= BASE2_RESET;
      base_level[3] <= BASE3_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEN0:  len_level[0]  <= cfg_data[3:0];
        REG_LEN1:  len_level[1]  <= cfg_data[3:0];
        REG_LEN2:  len_level[2]  <= cfg_data[3:0];
        REG_LEN3:  len_level[3]  <= cfg_data[3:0];
        REG_BASE0: base_level[0] <= cfg_data;
        REG_BASE1: base_level[1] <= cfg_data;
        REG_BASE2: base_level[2] <= cfg_data;
        REG_BASE3: base_level[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid implies a non-empty queue; the queue never holds more than one item's worth of results
  assert property (@(posedge clk) disable iff (rst) res_cnt != 2'd0 || !m_axis_tvalid)
    else $error("result valid with empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (pending_count == 3'd0 && pending_bits == 7'd0))
    else $error("accumulator not flushed after end of block");

  assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == 7'd0)
    else $error("stale bits above pending count");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))
    else $error("dropped item carries data");

  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !s_axis_tlast && dropped) |=> $stable(pending_count))
    else $error("dropped item changed the accumulator");

endmodule

FILE: verif/prefix_category_diff_encoder_unit_chk.sv
// Channel monitor for the encoder unit: predicts every coded byte and compares transfers.
module prefix_category_diff_encoder_unit_chk
  import pcde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] diff
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] packed_byte
  input  logic       m_axis_tlast,
  input  logic       m_axis_tuser,   // [0] no_category
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_data,
  output int         bytes_owed,
  output int         mismatches
);

  logic [3:0]  len_q  [NumLevels];
  logic [7:0]  base_q [NumLevels];
  logic [6:0]  acc_q;
  int unsigned cnt_q;
  res_t        coded_bytes [$];
  int          owed  = 0;
  int          fails = 0;

  assign bytes_owed = owed;
  assign mismatches = fails;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  // Appends prefix, offset value and sign to the bit accumulator, queues the bytes it completes.
  task automatic encode_diff(input logic [7:0] raw, input logic last);
    logic        neg;
    int unsigned mag;
    int unsigned lim;
    int unsigned vlen;
    int unsigned nbits;
    int unsigned hit;
    int unsigned made;
    logic [31:0] bits;
    res_t        r;
    neg  = raw[7];
    mag  = neg ? 32'd256 - 32'(raw) : 32'(raw);
    hit  = NumLevels;
    vlen = 0;
    made = 0;
    for (int i = 0; i < NumLevels; i++) begin
      lim = (len_q[i] > MAX_LEN) ? MAX_LEN : len_q[i];
      if (hit == NumLevels && mag >= base_q[i] && mag < base_q[i] + (32'd1 << lim)) begin
        hit  = i;
        vlen = lim;
      end
    end
    if (hit == NumLevels) begin
      // dropped item: accumulator untouched
      r = '{packed_byte: 8'h00, final_byte: 1'b0, no_category: 1'b1};
      coded_bytes.push_back(r);
    end else begin
      bits  = 32'(acc_q);
      nbits = cnt_q;
      bits  = (bits << PFX_SIZE[hit]) | 32'(PFX_CODE[hit]);
      bits  = (bits << vlen) | ((mag - base_q[hit]) & ((32'd1 << vlen) - 1));
      bits  = (bits << 1) | 32'(neg);
      nbits = nbits + PFX_SIZE[hit] + vlen + 1;
      while (nbits >= 8) begin
        nbits -= 8;
        r = '{packed_byte: bits[nbits +: 8], final_byte: 1'b0, no_category: 1'b0};
        coded_bytes.push_back(r);
        made++;
      end
      acc_q = 7'(bits & ((32'd1 << nbits) - 1));
      cnt_q = nbits;
    end
    if (last) begin
      if (cnt_q > 0) begin
        r = '{packed_byte: 8'({1'b0, acc_q} << (8 - cnt_q)), final_byte: 1'b1,
              no_category: 1'b0};
        coded_bytes.push_back(r);
      end else if (made > 0 && hit != NumLevels) begin
        // block ended on a byte boundary: the last full byte closes it
        coded_bytes[coded_bytes.size() - 1].final_byte = 1'b1;
      end
      acc_q = '0;
      cnt_q = 0;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      len_q[0]  = LEN0_RESET;
      len_q[1]  = LEN1_RESET;
      len_q[2]  = LEN2_RESET;
      len_q[3]  = LEN3_RESET;
      base_q[0] = BASE0_RESET;
      base_q[1] = BASE1_RESET;
      base_q[2] = BASE2_RESET;
      base_q[3] = BASE3_RESET;
      acc_q     = '0;
      cnt_q     = 0;
      coded_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr < REG_BASE0)
          len_q[cfg_addr[1:0]] = cfg_data[3:0];
        else
          base_q[cfg_addr[1:0]] = cfg_data;
      end
      // an output transfer at this edge can only belong to items taken earlier
      if (m_axis_tvalid && m_axis_tready) begin
        if (coded_bytes.size() == 0) begin
          report($sformatf("unexpected transfer tdata=%02h tlast=%b tuser=%b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end else begin
          want = coded_bytes.pop_front();
          if (m_axis_tdata !== want.packed_byte)
            report($sformatf("packed_byte %02h, want %02h", m_axis_tdata, want.packed_byte));
          if (m_axis_tlast !== want.final_byte)
            report($sformatf("final_byte %b, want %b (byte %02h)",
                             m_axis_tlast, want.final_byte, want.packed_byte));
          if (m_axis_tuser !== want.no_category)
            report($sformatf("no_category %b, want %b", m_axis_tuser, want.no_category));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_diff(s_axis_tdata, s_axis_tlast);
    end
    owed = coded_bytes.size();
  end

endmodule

FILE: verif/prefix_category_diff_encoder_unit_tb.sv
// Testbench top for the encoder unit: clock, reset, stimulus, output flow control and verdict.
module prefix_category_diff_encoder_unit_tb;
  import pcde_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;
  logic       cfg_we;
  logic [2:0] cfg_addr;
  logic [7:0] cfg_data;

  int   bytes_owed;
  int   mismatches;
  int   cycles    = 0;
  int   hold_asks = 0;
  logic tx_idle_en;
  logic rx_idle_en;

  prefix_category_diff_encoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  prefix_category_diff_encoder_unit_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .bytes_owed    (bytes_owed),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("prefix_category_diff_encoder_unit_tb: FAIL");
      $finish;
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen     = 0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = !(rx_idle_en && $urandom_range(0, 99) < 17);
      end
    end
  end

  task automatic send_item(input logic [7:0] d, input logic last);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop offering and wait until every coded byte is out, plus margin for accumulator updates
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // lens: four 4-bit lengths, bases: four 8-bit bases, category 0 in the low bits
  task automatic load_levels(input logic [15:0] lens, input logic [31:0] bases);
    for (int i = 0; i < NumLevels; i++) begin
      cfg_we   = 1'b1;
      cfg_addr = REG_LEN0 + 3'(i);
      cfg_data = {4'h0, lens[i*4 +: 4]};
      @(negedge clk);
      cfg_addr = REG_BASE0 + 3'(i);
      cfg_data = bases[i*8 +: 8];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [15:0] lens;
    logic [31:0] bases;
    int unsigned floor_b;
    logic [7:0]  d;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_LEN0;
    cfg_data      = '0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // power-up categories: every category edge, both signs, -128
    send_item(8'sd0, 1'b0);
    send_item(8'sd1, 1'b0);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd2, 1'b0);
    send_item(-8'sd5, 1'b0);
    send_item(8'sd6, 1'b0);
    send_item(8'sd21, 1'b0);
    send_item(-8'sd22, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'sd127, 1'b1);
    // two 12-bit codes end exactly on a byte boundary
    send_item(8'sd22, 1'b0);
    send_item(8'sd22, 1'b1);

    // zero-length and over-long categories, with gaps that drop items
    settle();
    load_levels({4'd3, 4'd2, 4'd15, 4'd0}, {8'd100, 8'd5, 8'd200, 8'd0});
    send_item(8'sd0, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'sd5, 1'b0);
    send_item(-8'sd8, 1'b0);
    send_item(8'sd107, 1'b0);
    send_item(8'sd1, 1'b1);        // dropped, pending bits flushed
    send_item(-8'sd100, 1'b1);
    send_item(8'sd10, 1'b1);       // dropped with nothing pending: no final byte
    send_item(8'sd127, 1'b0);

    // base at its top, length saturating at eight
    settle();
    load_levels({4'd0, 4'd0, 4'd15, 4'd8}, {8'd0, 8'd0, 8'd0, 8'd255});
    send_item(8'sd127, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'sd0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      settle();
      if (p % 2 == 0) begin
        // contiguous categories from zero up
        floor_b = 0;
        for (int i = 0; i < NumLevels; i++) begin
          lens[i*4 +: 4]  = 4'($urandom_range(0, 8));
          bases[i*8 +: 8] = 8'((floor_b > 255) ? 255 : floor_b);
          floor_b += 1 << lens[i*4 +: 4];
        end
      end else begin
        lens  = 16'($urandom);
        bases = $urandom;
      end
      load_levels(lens, bases);
      tx_idle_en = (p != 0);
      rx_idle_en = (p != 0);
      if (p == 1)
        hold_asks++;
      for (int n = 0; n < 20; n++) begin
        d = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 60) - 30);
        send_item(d, $urandom_range(0, 7) == 0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("prefix_category_diff_encoder_unit_tb: PASS");
    else
      $display("prefix_category_diff_encoder_unit_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pcde_pkg.sv
rtl/core/prefix_category_diff_encoder_unit.sv
verif/prefix_category_diff_encoder_unit_chk.sv
verif/prefix_category_diff_encoder_unit_tb.sv
